FILE: rtl/rln_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and structs of the relative L2 error block.
// No dependencies; every other file of the block uses it.
package rln_pkg;

  localparam int DATA_W    = 32;
  localparam int ENERGY_W  = 64;
  localparam int OUT_CNT_W = 24;

  localparam logic [DATA_W-1:0]    REL_MAX          = '1;
  localparam logic [ENERGY_W-1:0]  ENERGY_MAX       = '1;
  localparam logic [OUT_CNT_W-1:0] MISMATCH_OUT_MAX = '1;

  // One classified pair, as it travels from the front to the back
  typedef struct packed {
    logic [ENERGY_W-1:0] diff_sq;
    logic [ENERGY_W-1:0] ref_sq;
    logic                diff_big;
    logic                mismatch;
    logic                last;
  } term_t;

  // One result beat
  typedef struct packed {
    logic [DATA_W-1:0]    rel_error;
    logic [OUT_CNT_W-1:0] mismatch_count;
    logic                 zero_reference;
    logic                 sum_saturated;
  } result_t;

endpackage

FILE: rtl/rln_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: element pairs in, results out, threshold writes.
// Depends on rln_pkg for field widths.
interface rln_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [rln_pkg::DATA_W-1:0] ref_value;
  logic signed [rln_pkg::DATA_W-1:0] cmp_value;
  logic                             last;
  modport source (output valid, ref_value, cmp_value, last, input ready);
  modport sink   (input valid, ref_value, cmp_value, last, output ready);
endinterface

interface rln_out_if;
  logic                          valid;
  logic                          ready;
  logic [rln_pkg::DATA_W-1:0]    rel_error;
  logic [rln_pkg::OUT_CNT_W-1:0] mismatch_count;
  logic                          zero_reference;
  logic                          sum_saturated;
  modport source (output valid, rel_error, mismatch_count, zero_reference, sum_saturated,
                  input ready);
  modport sink   (input valid, rel_error, mismatch_count, zero_reference, sum_saturated,
                  output ready);
endinterface

interface rln_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rln_pkg::DATA_W-1:0] mismatch_threshold;
  modport source (output valid, mismatch_threshold, input ready);
  modport sink   (input valid, mismatch_threshold, output ready);
endinterface

FILE: rtl/rln_front.sv
`timescale 1ns / 1ps
// Front end: takes element pairs, forms difference, magnitudes, mismatch flag and squares.
// Three register stages with a ready chain; depends on rln_pkg.
module rln_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rln_pkg::DATA_W-1:0] ref_value,
  input  logic signed [rln_pkg::DATA_W-1:0] cmp_value,
  input  logic                              last,
  input  logic [rln_pkg::DATA_W-1:0]        threshold,
  output logic                              term_valid,
  input  logic                              term_ready,
  output rln_pkg::term_t                    term
);

  localparam int DW = rln_pkg::DATA_W;

  logic                s1_valid_r, s2_valid_r, s3_valid_r;
  logic signed [DW:0]  s1_diff_r;
  logic signed [DW-1:0] s1_ref_r;
  logic                s1_last_r;
  logic [DW:0]         s2_adiff_r;
  logic [DW-1:0]       s2_aref_r;
  logic                s2_mis_r, s2_last_r;
  rln_pkg::term_t      s3_term_r;

  logic s1_adv, s2_adv, s3_adv;
  logic [DW:0]   adiff_nxt;
  logic [DW-1:0] aref_nxt;

  // Advance a stage when it is empty or the next one takes its beat
  assign s3_adv   = !s3_valid_r || term_ready;
  assign s2_adv   = !s2_valid_r || s3_adv;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_ready = s1_adv;

  // Magnitudes of the difference and of the reference element
  assign adiff_nxt = s1_diff_r[DW] ? (DW+1)'(-s1_diff_r) : (DW+1)'(s1_diff_r);
  assign aref_nxt  = s1_ref_r[DW-1] ? DW'(-s1_ref_r) : DW'(s1_ref_r);

  // Stage 1: exact difference in one extra bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
    if (s1_adv && in_valid) begin
      s1_diff_r <= {ref_value[DW-1], ref_value} - {cmp_value[DW-1], cmp_value};
      s1_ref_r  <= ref_value;
      s1_last_r <= last;
    end
  end

  // Stage 2: magnitudes and threshold compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s2_adv && s1_valid_r) begin
      s2_adiff_r <= adiff_nxt;
      s2_aref_r  <= aref_nxt;
      s2_mis_r   <= adiff_nxt > {1'b0, threshold};
      s2_last_r  <= s1_last_r;
    end
  end

  // Stage 3: squares; a difference of full 2^32 is flagged instead of squared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_adv) begin
      s3_valid_r <= s2_valid_r;
    end
    if (s3_adv && s2_valid_r) begin
      s3_term_r.diff_sq  <= {32'd0, s2_adiff_r[DW-1:0]} * {32'd0, s2_adiff_r[DW-1:0]};
      s3_term_r.ref_sq   <= {32'd0, s2_aref_r} * {32'd0, s2_aref_r};
      s3_term_r.diff_big <= s2_adiff_r[DW];
      s3_term_r.mismatch <= s2_mis_r;
      s3_term_r.last     <= s2_last_r;
    end
  end

  assign term_valid = s3_valid_r;
  assign term       = s3_term_r;

endmodule

FILE: rtl/rln_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified terms between front and back.
// Depends on rln_pkg for the term struct.
module rln_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rln_pkg::term_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rln_pkg::term_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rln_pkg::term_t   mem_r [DEPTH];
  logic [PTR_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[head_r];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Store a pushed beat at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= push_data;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) tail_r <= wrap_inc(tail_r);
      if (pop)  head_r <= wrap_inc(head_r);
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/rln_back.sv
`timescale 1ns / 1ps
// Back end: saturating accumulation, bit-serial fraction divide, bit-pair square root,
// result register. Depends on rln_pkg.
module rln_back #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             term_valid,
  output logic             term_ready,
  input  rln_pkg::term_t   term,
  output logic             out_valid,
  input  logic             out_ready,
  output rln_pkg::result_t out_data
);

  localparam int EW     = rln_pkg::ENERGY_W;
  localparam int DW     = rln_pkg::DATA_W;
  localparam int DIV_STEPS = EW + DW;
  localparam int STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [4:0] {
    ST_ACC   = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_ROOT  = 5'b01000,
    ST_DONE  = 5'b10000
  } back_state_t;

  back_state_t            state_r;
  logic [EW-1:0]          diff_r, ref_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic                   ovf_r, zero_r;
  logic [EW-1:0]          num_r, rem_r, quo_r;
  logic [STEP_W-1:0]      step_r;
  logic [EW-1:0]          sq_v_r, sq_res_r, sq_bit_r;
  logic [DW-1:0]          rel_r;
  logic                   out_valid_r;
  rln_pkg::result_t       out_r;

  logic                   pop;
  logic [EW:0]            diff_sum, ref_sum;
  logic [EW:0]            div_rs;
  logic                   div_hit;
  logic [EW-1:0]          quo_nxt;
  logic [EW-1:0]          sq_sum, sq_res_nxt;
  logic                   sq_hit;
  logic                   load_out;
  logic [31:0]            cnt_ext;
  logic [rln_pkg::OUT_CNT_W-1:0] cnt_out;

  assign term_ready = state_r == ST_ACC;
  assign pop        = term_valid && term_ready;

  // Sums one bit wider to catch carry out
  assign diff_sum = {1'b0, diff_r} + {1'b0, term.diff_sq};
  assign ref_sum  = {1'b0, ref_r} + {1'b0, term.ref_sq};

  // Restoring divide step: shift in the next dividend bit, subtract if it fits
  assign div_rs  = {rem_r, num_r[EW-1]};
  assign div_hit = div_rs >= {1'b0, ref_r};
  assign quo_nxt = {quo_r[EW-2:0], div_hit};

  // Square root step over bit pairs
  assign sq_sum     = sq_res_r + sq_bit_r;
  assign sq_hit     = sq_v_r >= sq_sum;
  assign sq_res_nxt = sq_hit ? (sq_res_r >> 1) + sq_bit_r : sq_res_r >> 1;

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Clamp the counter to the width of the result field
  assign cnt_ext = 32'(cnt_r);
  assign cnt_out = (cnt_ext > 32'(rln_pkg::MISMATCH_OUT_MAX)) ? rln_pkg::MISMATCH_OUT_MAX
                                                              : cnt_ext[rln_pkg::OUT_CNT_W-1:0];

  // Sequencer, accumulators and arithmetic registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      diff_r  <= '0;
      ref_r   <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_ACC: begin
          if (pop) begin
            if (term.mismatch && (cnt_r != '1)) begin
              cnt_r <= cnt_r + 1'b1;
            end
            if (term.diff_big || diff_sum[EW]) begin
              diff_r <= rln_pkg::ENERGY_MAX;
            end else begin
              diff_r <= diff_sum[EW-1:0];
            end
            if (ref_sum[EW]) begin
              ref_r <= rln_pkg::ENERGY_MAX;
            end else begin
              ref_r <= ref_sum[EW-1:0];
            end
            if (term.diff_big || diff_sum[EW] || ref_sum[EW]) begin
              ovf_r <= 1'b1;
            end
            if (term.last) begin
              state_r <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          zero_r <= ref_r == '0;
          if ((ref_r == '0) || ({32'd0, diff_r[EW-1:DW]} >= ref_r)) begin
            rel_r   <= rln_pkg::REL_MAX;
            state_r <= ST_DONE;
          end else begin
            num_r   <= diff_r;
            rem_r   <= '0;
            quo_r   <= '0;
            step_r  <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r  <= div_hit ? EW'(div_rs - {1'b0, ref_r}) : div_rs[EW-1:0];
          num_r  <= {num_r[EW-2:0], 1'b0};
          quo_r  <= quo_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(DIV_STEPS - 1)) begin
            sq_v_r   <= quo_nxt;
            sq_res_r <= '0;
            sq_bit_r <= EW'(1) << (EW - 2);
            state_r  <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (sq_hit) begin
            sq_v_r <= sq_v_r - sq_sum;
          end
          sq_res_r <= sq_res_nxt;
          sq_bit_r <= sq_bit_r >> 2;
          if (sq_bit_r[0]) begin
            rel_r   <= sq_res_nxt[DW-1:0];
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hand the result over, then clear for the next matrix
          if (load_out) begin
            diff_r  <= '0;
            ref_r   <= '0;
            cnt_r   <= '0;
            ovf_r   <= 1'b0;
            state_r <= ST_ACC;
          end
        end
        default: begin
          state_r <= ST_ACC;
        end
      endcase
    end
  end

  // Result register: holds a beat while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      out_r.rel_error      <= rel_r;
      out_r.mismatch_count <= cnt_out;
      out_r.zero_reference <= zero_r;
      out_r.sum_saturated  <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/relative_l2_error_norm.sv
`timescale 1ns / 1ps
// Relative L2 (Frobenius) error: one element pair per cycle while in_ch.ready is high,
// result on the last pair. Path: 3 front stages, queue, accumulate, check, 96-step divide,
// 32-step square root, result load; a saturated ratio skips divide and square root.
// After a last term the back end takes no terms until its result loads, later while one waits.
// Reset (rst_n low, synchronous): threshold 0, sums, counter and overflow flag cleared, queue empty.
module relative_l2_error_norm #(
  parameter int COUNT_WIDTH = 24,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  rln_cfg_if.sink  cfg_ch,
  rln_in_if.sink   in_ch,
  rln_out_if.source out_ch
);

  logic [rln_pkg::DATA_W-1:0] thr_r;
  logic                       f_valid, f_ready;
  rln_pkg::term_t             f_term;
  logic                       q_valid, b_ready;
  rln_pkg::term_t             q_term;
  rln_pkg::result_t           res;

  // Threshold register, always ready for a write beat
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_ch.valid) begin
      thr_r <= cfg_ch.mismatch_threshold;
    end
  end

  rln_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .ref_value  (in_ch.ref_value),
    .cmp_value  (in_ch.cmp_value),
    .last       (in_ch.last),
    .threshold  (thr_r),
    .term_valid (f_valid),
    .term_ready (f_ready),
    .term       (f_term)
  );

  rln_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_term),
    .pop_valid  (q_valid),
    .pop_ready  (b_ready),
    .pop_data   (q_term)
  );

  rln_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .term_valid (q_valid),
    .term_ready (b_ready),
    .term       (q_term),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (res)
  );

  assign out_ch.rel_error      = res.rel_error;
  assign out_ch.mismatch_count = res.mismatch_count;
  assign out_ch.zero_reference = res.zero_reference;
  assign out_ch.sum_saturated  = res.sum_saturated;

  // The back end stops taking terms once it has taken a last one
  a_last_stops_intake: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && b_ready && q_term.last) |=> !b_ready)
    else $error("back end took a term while finishing a matrix");

  // A zero reference energy always reports a saturated error
  a_zero_ref_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.zero_reference) |-> (out_ch.rel_error == rln_pkg::REL_MAX))
    else $error("zero reference without saturated error");

  // No result beat right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result beat present after reset");

endmodule
